### rtl/core/ucdw_pkg.sv
`default_nettype none

package ucdw_pkg;

    // Record kinds reported with each descriptor.
    localparam logic [3:0] KIND_CONFIG    = 4'd0;
    localparam logic [3:0] KIND_IAD       = 4'd1;
    localparam logic [3:0] KIND_INTERFACE = 4'd2;
    localparam logic [3:0] KIND_ENDPOINT  = 4'd3;
    localparam logic [3:0] KIND_VC_CS     = 4'd4;
    localparam logic [3:0] KIND_VS_CS     = 4'd5;
    localparam logic [3:0] KIND_CS_IFACE  = 4'd6;
    localparam logic [3:0] KIND_CS_EP     = 4'd7;
    localparam logic [3:0] KIND_OTHER     = 4'd8;

    // Walk status codes.
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_MALFORMED = 2'd1;
    localparam logic [1:0] STATUS_BAD_HDR   = 2'd2;
    localparam logic [1:0] STATUS_TOO_SHORT = 2'd3;

    // Descriptor type codes.
    localparam logic [7:0] DT_CONFIG    = 8'h02;
    localparam logic [7:0] DT_INTERFACE = 8'h04;
    localparam logic [7:0] DT_ENDPOINT  = 8'h05;
    localparam logic [7:0] DT_IAD       = 8'h0B;
    localparam logic [7:0] DT_CS_IFACE  = 8'h24;
    localparam logic [7:0] DT_CS_EP     = 8'h25;

    // Video class context.
    localparam logic [7:0] CLASS_VIDEO     = 8'h0E;
    localparam logic [7:0] SUBCLASS_VC     = 8'h01;
    localparam logic [7:0] SUBCLASS_VS     = 8'h02;

    localparam logic [10:0] MAX_PACKET_MASK = 11'h7FF;

    // Configuration header size and number of held body bytes.
    localparam int HDR_LEN   = 9;
    localparam int NUM_HELD  = 5;

    typedef logic [NUM_HELD-1:0][7:0] held_bytes_t;

    // Decoded view of a completed descriptor.
    typedef struct packed {
        logic [3:0]  kind;
        logic [7:0]  second;
        logic [7:0]  third;
        logic [10:0] max_packet;
        logic        ctx_update;
        logic [7:0]  ctx_class;
        logic [7:0]  ctx_subclass;
    } decode_t;

endpackage

`default_nettype wire

### rtl/core/ucdw_classify.sv
`default_nettype none

module ucdw_classify
    import ucdw_pkg::*;
(
    input  wire logic [7:0] desc_len,
    input  wire logic [7:0] desc_type,
    input  wire held_bytes_t held,
    input  wire logic [7:0] cur_class,
    input  wire logic [7:0] cur_subclass,
    output decode_t         dec
);

    always_comb begin
        dec.kind         = KIND_OTHER;
        dec.max_packet   = '0;
        dec.ctx_update   = 1'b0;
        dec.ctx_class    = held[3];
        dec.ctx_subclass = held[4];

        // Byte 2 and byte 3 are reported only when the length covers them.
        dec.second = (desc_len >= 8'd3) ? held[0] : 8'd0;
        dec.third  = (desc_len >= 8'd4) ? held[1] : 8'd0;

        case (desc_type)
            DT_CONFIG: begin
                dec.kind = KIND_CONFIG;
            end
            DT_IAD: begin
                dec.kind = KIND_IAD;
            end
            DT_INTERFACE: begin
                dec.kind       = KIND_INTERFACE;
                dec.ctx_update = (desc_len >= 8'd9);
            end
            DT_ENDPOINT: begin
                dec.kind = KIND_ENDPOINT;
                if (desc_len >= 8'd7) begin
                    dec.max_packet = {held[3][2:0], held[2]} & MAX_PACKET_MASK;
                end
            end
            DT_CS_IFACE: begin
                // Class-specific interface descriptors follow the current context.
                if (cur_class == CLASS_VIDEO && cur_subclass == SUBCLASS_VC) begin
                    dec.kind = KIND_VC_CS;
                end else if (cur_class == CLASS_VIDEO && cur_subclass == SUBCLASS_VS) begin
                    dec.kind = KIND_VS_CS;
                end else begin
                    dec.kind = KIND_CS_IFACE;
                end
            end
            DT_CS_EP: begin
                dec.kind = KIND_CS_EP;
            end
            default: begin
                dec.kind = KIND_OTHER;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/usb_config_descriptor_walker.sv
`default_nettype none

// Walks a USB configuration descriptor blob presented one byte per request on
// the slave stream, with s_tlast on the last available byte. It checks the
// nine-byte configuration header, clamps the total length to the bytes
// actually delivered, and emits one record per descriptor on the master
// stream, in the cycle after the descriptor's last byte is taken. A new byte is
// taken every cycle while the output register is empty or being drained. The
// record kind travels in m_tuser and m_tlast marks the record that ends the
// walk, after which all bytes are consumed and dropped until reset. Malformed
// input ends the walk with an error record of kind "other" and a nonzero
// status.
module usb_config_descriptor_walker
    import ucdw_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,   // last_byte

    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [15:0] record_offset, [23:16] record_length, [31:24] record_type,
    // [39:32] second_field, [47:40] third_field, [55:48] context_class,
    // [63:56] context_subclass, [74:64] max_packet, [76:75] walk_status,
    // [79:77] zero
    output logic [79:0]      m_tdata,
    output logic             m_tlast,   // walk_done
    output logic [3:0]       m_tuser    // [3:0] record_kind
);

    // Walk state.
    logic [15:0] pos_reg, pos_next;
    logic [15:0] limit_reg, limit_next;
    logic [15:0] start_reg, start_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  type_reg, type_next;
    held_bytes_t held_reg, held_next;
    logic [7:0]  class_reg, class_next;
    logic [7:0]  subclass_reg, subclass_next;
    logic        stopped_reg, stopped_next;

    // Output register.
    logic        out_valid_reg;
    logic [3:0]  out_kind_reg;
    logic [15:0] out_offset_reg;
    logic [7:0]  out_len_reg;
    logic [7:0]  out_type_reg;
    logic [7:0]  out_second_reg;
    logic [7:0]  out_third_reg;
    logic [7:0]  out_class_reg;
    logic [7:0]  out_subclass_reg;
    logic [10:0] out_mp_reg;
    logic [1:0]  out_status_reg;
    logic        out_done_reg;

    logic        accept;
    logic [15:0] rel;
    logic        rel_is0, rel_is1, rel_held;
    logic [2:0]  held_idx;
    logic [7:0]  b;
    logic        hdr;
    logic [16:0] pos_inc;
    logic [15:0] lim;
    logic [16:0] desc_end;
    logic [17:0] done_sum;
    logic        do_fail, do_finish;
    logic [1:0]  fail_status;
    logic        finish_done;
    decode_t     dec;

    assign b        = s_tdata;
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Position of this byte within the current descriptor.
    assign rel      = pos_reg - start_reg;
    assign rel_is0  = (rel == 16'd0);
    assign rel_is1  = (rel == 16'd1);
    assign rel_held = (rel >= 16'd2) && (rel <= 16'd6);
    assign held_idx = rel[2:0] - 3'd2;
    assign hdr      = (pos_reg < 16'(HDR_LEN));
    assign pos_inc  = {1'b0, pos_reg} + 17'd1;

    // Latches with the current byte merged in.
    always_comb begin
        len_next  = rel_is0 ? b : len_reg;
        type_next = rel_is0 ? 8'd0 : (rel_is1 ? b : type_reg);
        for (int i = 0; i < NUM_HELD; i++) begin
            held_next[i] = (rel_held && held_idx == 3'(i)) ? b : held_reg[i];
        end
    end

    ucdw_classify u_classify (
        .desc_len     (len_next),
        .desc_type    (type_next),
        .held         (held_next),
        .cur_class    (class_reg),
        .cur_subclass (subclass_reg),
        .dec          (dec)
    );

    // Descriptor end and walk decisions for this byte.
    always_comb begin
        do_fail      = 1'b0;
        do_finish    = 1'b0;
        fail_status  = STATUS_OK;
        stopped_next = stopped_reg;
        limit_next   = limit_reg;
        lim          = limit_reg;
        desc_end     = {1'b0, start_reg} + {9'd0, len_next};
        done_sum     = {1'b0, desc_end} + 18'd2;
        finish_done  = 1'b0;

        if (hdr) begin
            if (pos_reg == 16'd3) begin
                limit_next = {b, held_next[0]};
            end
            if (pos_reg < 16'd8) begin
                if ((pos_reg == 16'd1 && b != DT_CONFIG) || s_tlast) begin
                    do_fail     = 1'b1;
                    fail_status = STATUS_BAD_HDR;
                end
            end else begin
                // Last header byte: clamp, then check the header's own length.
                lim = (s_tlast && limit_reg > 16'(HDR_LEN)) ? 16'(HDR_LEN) : limit_reg;
                limit_next = lim;
                if (lim < 16'd2) begin
                    stopped_next = 1'b1;
                end else if (len_next < 8'd2) begin
                    do_fail     = 1'b1;
                    fail_status = STATUS_TOO_SHORT;
                end else if ({8'd0, len_next} > lim) begin
                    do_fail     = 1'b1;
                    fail_status = STATUS_MALFORMED;
                end else if (len_next < 8'(HDR_LEN)) begin
                    do_fail     = 1'b1;
                    fail_status = STATUS_TOO_SHORT;
                end else if (len_next == 8'(HDR_LEN)) begin
                    do_finish = 1'b1;
                end
            end
        end else begin
            // Body: clamp the total to the bytes delivered so far.
            lim = (s_tlast && {1'b0, limit_reg} > pos_inc) ? pos_inc[15:0] : limit_reg;
            limit_next = lim;
            if (rel_is0) begin
                // A lone trailing byte starts no descriptor.
                if ({1'b0, start_reg} + 17'd2 > {1'b0, lim}) begin
                    stopped_next = 1'b1;
                end
            end else if (rel_is1 && len_next < 8'd2) begin
                do_fail     = 1'b1;
                fail_status = STATUS_TOO_SHORT;
            end else if (desc_end > {1'b0, lim}) begin
                do_fail     = 1'b1;
                fail_status = STATUS_MALFORMED;
            end else if (pos_inc == desc_end) begin
                do_finish = 1'b1;
            end
        end

        if (do_finish) begin
            finish_done = (done_sum > {2'd0, lim});
        end
        if (do_fail || (do_finish && finish_done)) begin
            stopped_next = 1'b1;
        end
    end

    // Class context and next descriptor start.
    always_comb begin
        class_next    = class_reg;
        subclass_next = subclass_reg;
        start_next    = start_reg;
        if (do_finish) begin
            start_next = desc_end[15:0];
            if (dec.ctx_update) begin
                class_next    = dec.ctx_class;
                subclass_next = dec.ctx_subclass;
            end
        end
    end

    // Walk state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            limit_reg    <= '0;
            start_reg    <= '0;
            len_reg      <= '0;
            type_reg     <= '0;
            class_reg    <= '0;
            subclass_reg <= '0;
            stopped_reg  <= 1'b0;
        end else if (accept && !stopped_reg) begin
            pos_reg      <= pos_next;
            limit_reg    <= limit_next;
            start_reg    <= start_next;
            len_reg      <= len_next;
            type_reg     <= type_next;
            class_reg    <= class_next;
            subclass_reg <= subclass_next;
            stopped_reg  <= stopped_next;
        end
    end

    assign pos_next = pos_inc[15:0];

    // Held descriptor bytes carry no reset.
    always_ff @(posedge aclk) begin
        if (accept && !stopped_reg) begin
            held_reg <= held_next;
        end
    end

    // Output register: loaded by a record, cleared when taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept && !stopped_reg && (do_fail || do_finish)) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && !stopped_reg && (do_fail || do_finish)) begin
            out_offset_reg <= start_reg;
            out_len_reg    <= len_next;
            out_type_reg   <= type_next;
            if (do_fail) begin
                out_kind_reg     <= KIND_OTHER;
                out_second_reg   <= 8'd0;
                out_third_reg    <= 8'd0;
                out_mp_reg       <= 11'd0;
                out_status_reg   <= fail_status;
                out_done_reg     <= 1'b1;
                out_class_reg    <= class_reg;
                out_subclass_reg <= subclass_reg;
            end else begin
                out_kind_reg     <= dec.kind;
                out_second_reg   <= dec.second;
                out_third_reg    <= dec.third;
                out_mp_reg       <= dec.max_packet;
                out_status_reg   <= STATUS_OK;
                out_done_reg     <= finish_done;
                out_class_reg    <= class_next;
                out_subclass_reg <= subclass_next;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_done_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {3'd0, out_status_reg, out_mp_reg, out_subclass_reg, out_class_reg,
                       out_third_reg, out_second_reg, out_type_reg, out_len_reg,
                       out_offset_reg};

`ifndef ASSERT_OFF
    // Once the walk has stopped, no new record is produced.
    a_no_record_after_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        (stopped_reg && !out_valid_reg) |=> !out_valid_reg)
        else $error("record produced after the walk stopped");

    // A record that ends the walk leaves the walk stopped.
    a_done_stops_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !stopped_reg && (do_fail || (do_finish && finish_done)))
            |=> stopped_reg)
        else $error("walk did not stop after its final record");

    // Error records always end the walk.
    a_error_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_status_reg != STATUS_OK) |-> (out_done_reg &&
            out_kind_reg == KIND_OTHER))
        else $error("error record not marked as final");
`endif

endmodule

`default_nettype wire

### dv/tb.sv
`timescale 1ns / 100ps

module tb;
    import ucdw_pkg::*;

    localparam int IDLE_PCT      = 22;
    localparam int CALM_FROM     = 300;
    localparam int CALM_TO       = 650;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 32;
    localparam int BODY_BYTES    = 680;
    localparam int NOISE_BYTES   = 16;
    localparam int IFACE_MIN_LEN = 9;
    localparam int EP_MIN_LEN    = 7;

    // How the blob of this run ends; the block takes one reset, so one walk per run.
    typedef enum {
        END_CLEAN, END_STRAY, END_PAST_TOTAL, END_CUT_SHORT, END_LEN_TINY,
        END_HDR_TYPE, END_HDR_SHORT, END_TOTAL_TINY, END_CFG_SHORT, END_CFG_PAST,
        END_CFG_CLAMP
    } walk_end_e;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } blob_item_t;

    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] offset;
        logic [7:0]  length;
        logic [7:0]  dtype;
        logic [7:0]  second;
        logic [7:0]  third;
        logic [7:0]  cls;
        logic [7:0]  subcls;
        logic [10:0] max_packet;
        logic [1:0]  status;
        logic        done;
    } walk_rec_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic        m_tlast;
    logic [3:0]  m_tuser;

    logic [7:0]   blob [$];
    blob_item_t   blob_items [$];
    walk_rec_t    pending_records [$];
    walk_end_e    end_case;

    int unsigned cycle_count = 0;
    int unsigned quiet_cycles = 0;
    int unsigned bytes_taken = 0;
    int unsigned records_checked = 0;
    int unsigned error_count = 0;
    logic [8:0]  kinds_seen = '0;
    logic        calm;

    // Predicted walker state.
    int unsigned next_pos = 0;
    int unsigned walk_end = 0;
    int unsigned desc_start = 0;
    logic [7:0]  desc_len = 8'h00;
    logic [7:0]  desc_type = 8'h00;
    logic [7:0]  desc_body [NUM_HELD] = '{default: 8'h00};
    logic [7:0]  ctx_class = 8'h00;
    logic [7:0]  ctx_subclass = 8'h00;
    logic        walk_over = 1'b0;

    usb_config_descriptor_walker dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    assign calm = (cycle_count >= CALM_FROM) && (cycle_count < CALM_TO);

    function automatic string rec_text(input walk_rec_t r);
        return $sformatf({"kind=%0d off=%0d len=%0d type=%02h b2=%02h b3=%02h ",
                          "class=%02h/%02h mps=%0d status=%0d done=%0b"},
                         r.kind, r.offset, r.length, r.dtype, r.second, r.third,
                         r.cls, r.subcls, r.max_packet, r.status, r.done);
    endfunction

    task automatic note_error(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    task automatic push_record(input logic [3:0] kind, input logic [7:0] second,
                               input logic [7:0] third, input logic [10:0] mp,
                               input logic [1:0] status, input logic ends);
        pending_records.push_back('{kind: kind, offset: desc_start[15:0], length: desc_len,
                                    dtype: desc_type, second: second, third: third,
                                    cls: ctx_class, subcls: ctx_subclass, max_packet: mp,
                                    status: status, done: ends});
    endtask

    // An error record ends the walk and carries only what was latched.
    task automatic stop_walk(input logic [1:0] status);
        walk_over = 1'b1;
        push_record(KIND_OTHER, 8'h00, 8'h00, 11'h000, status, 1'b1);
    endtask

    // The descriptor's last byte has arrived: classify it and move to the next one.
    task automatic close_descriptor();
        logic [3:0]  kind;
        logic [10:0] mp;
        logic [7:0]  second;
        logic [7:0]  third;
        int unsigned after;
        logic        ends;
        kind = KIND_OTHER;
        mp = '0;
        second = (desc_len >= 3) ? desc_body[0] : 8'h00;
        third = (desc_len >= 4) ? desc_body[1] : 8'h00;
        after = desc_start + 32'(desc_len);
        case (desc_type)
            DT_CONFIG: kind = KIND_CONFIG;
            DT_IAD:    kind = KIND_IAD;
            DT_INTERFACE: begin
                kind = KIND_INTERFACE;
                // Only a full interface descriptor changes the class context.
                if (desc_len >= IFACE_MIN_LEN) begin
                    ctx_class = desc_body[3];
                    ctx_subclass = desc_body[4];
                end
            end
            DT_ENDPOINT: begin
                kind = KIND_ENDPOINT;
                if (desc_len >= EP_MIN_LEN)
                    mp = 11'({desc_body[3], desc_body[2]}) & MAX_PACKET_MASK;
            end
            DT_CS_IFACE: begin
                if (ctx_class == CLASS_VIDEO && ctx_subclass == SUBCLASS_VC)
                    kind = KIND_VC_CS;
                else if (ctx_class == CLASS_VIDEO && ctx_subclass == SUBCLASS_VS)
                    kind = KIND_VS_CS;
                else
                    kind = KIND_CS_IFACE;
            end
            DT_CS_EP: kind = KIND_CS_EP;
            default:  kind = KIND_OTHER;
        endcase
        ends = (after + 2 > walk_end);
        push_record(kind, second, third, mp, STATUS_OK, ends);
        desc_start = after;
        if (ends)
            walk_over = 1'b1;
    endtask

    // Advance the predicted walk by one accepted byte.
    task automatic walk_descriptor_byte(input logic [7:0] b, input logic last);
        int unsigned pos;
        int unsigned rel;
        int unsigned desc_end;
        if (walk_over)
            return;
        pos = next_pos;
        rel = pos - desc_start;
        next_pos = (pos + 1) & 16'hFFFF;
        if (rel == 0) begin
            desc_len = b;
            desc_type = 8'h00;
        end else if (rel == 1) begin
            desc_type = b;
        end else if (rel <= 6) begin
            desc_body[3'(rel - 2)] = b;
        end

        // Configuration header checks.
        if (pos < HDR_LEN) begin
            if (pos == 1 && b != DT_CONFIG) begin
                stop_walk(STATUS_BAD_HDR);
                return;
            end
            if (pos == 3)
                walk_end = 32'({b, desc_body[0]});
            if (pos < HDR_LEN - 1) begin
                if (last)
                    stop_walk(STATUS_BAD_HDR);
                return;
            end
            if (last && walk_end > HDR_LEN)
                walk_end = HDR_LEN;
            if (walk_end < 2)
                walk_over = 1'b1;
            else if (desc_len < 2)
                stop_walk(STATUS_TOO_SHORT);
            else if (32'(desc_len) > walk_end)
                stop_walk(STATUS_MALFORMED);
            else if (desc_len < HDR_LEN)
                stop_walk(STATUS_TOO_SHORT);
            else if (desc_len == HDR_LEN)
                close_descriptor();
            return;
        end

        // Body: clamp to the delivered bytes, then follow the length chain.
        if (last && walk_end > pos + 1)
            walk_end = pos + 1;
        if (rel == 0) begin
            if (desc_start + 2 > walk_end)
                walk_over = 1'b1;
            return;
        end
        desc_end = desc_start + 32'(desc_len);
        if (rel == 1 && desc_len < 2)
            stop_walk(STATUS_TOO_SHORT);
        else if (desc_end > walk_end)
            stop_walk(STATUS_MALFORMED);
        else if (pos + 1 == desc_end)
            close_descriptor();
    endtask

    // Append one descriptor with random filler and the fields that matter placed.
    task automatic add_desc(input int len, input logic [7:0] dtype, input logic [7:0] cls,
                            input logic [7:0] sub, input logic [15:0] mps);
        int base;
        base = blob.size();
        blob.push_back(8'(len));
        blob.push_back(dtype);
        for (int i = 2; i < len; i++)
            blob.push_back(8'($urandom));
        if (dtype == DT_INTERFACE && len >= 7) begin
            blob[base + 5] = cls;
            blob[base + 6] = sub;
        end
        if (dtype == DT_ENDPOINT && len >= 6) begin
            blob[base + 4] = mps[7:0];
            blob[base + 5] = mps[15:8];
        end
    endtask

    // Source side: present queued bytes, holding each request until it is taken.
    always @(posedge aclk) begin : driver
        blob_item_t item;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                walk_descriptor_byte(s_tdata, s_tlast);
                bytes_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (blob_items.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    item = blob_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= item.data;
                    s_tlast <= item.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Sink side: check each record against the oldest prediction.
    always @(posedge aclk) begin : monitor
        walk_rec_t got;
        walk_rec_t want;
        string     diff;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.kind = m_tuser;
                got.offset = m_tdata[15:0];
                got.length = m_tdata[23:16];
                got.dtype = m_tdata[31:24];
                got.second = m_tdata[39:32];
                got.third = m_tdata[47:40];
                got.cls = m_tdata[55:48];
                got.subcls = m_tdata[63:56];
                got.max_packet = m_tdata[74:64];
                got.status = m_tdata[76:75];
                got.done = m_tlast;
                records_checked++;
                if (m_tuser <= KIND_OTHER)
                    kinds_seen[m_tuser] = 1'b1;
                if (pending_records.size() == 0) begin
                    note_error($sformatf("unexpected record %s", rec_text(got)));
                end else begin
                    want = pending_records.pop_front();
                    diff = "";
                    if (got.kind !== want.kind) diff = {diff, " kind"};
                    if (got.offset !== want.offset) diff = {diff, " offset"};
                    if (got.length !== want.length) diff = {diff, " length"};
                    if (got.dtype !== want.dtype) diff = {diff, " type"};
                    if (got.second !== want.second) diff = {diff, " byte2"};
                    if (got.third !== want.third) diff = {diff, " byte3"};
                    if (got.cls !== want.cls) diff = {diff, " class"};
                    if (got.subcls !== want.subcls) diff = {diff, " subclass"};
                    if (got.max_packet !== want.max_packet) diff = {diff, " max_packet"};
                    if (got.status !== want.status) diff = {diff, " status"};
                    if (got.done !== want.done) diff = {diff, " done"};
                    if (m_tdata[79:77] !== 3'b000) diff = {diff, " padding"};
                    if (diff != "")
                        note_error($sformatf("record mismatch in%s\n  expected %s\n  actual   %s",
                                             diff, rec_text(want), rec_text(got)));
                end
            end
            m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Progress watchdog: any transfer taken on either side counts as progress.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no request for %0d cycles, %0d bytes queued, %0d records owed",
                     quiet_cycles, blob_items.size(), pending_records.size());
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int r;
        int total;
        int cut;
        int len;

        // Pick how this run's walk ends; header failures are kept rare.
        r = $urandom_range(0, 99);
        if (r < 24)      end_case = END_CLEAN;
        else if (r < 42) end_case = END_STRAY;
        else if (r < 58) end_case = END_PAST_TOTAL;
        else if (r < 74) end_case = END_CUT_SHORT;
        else if (r < 88) end_case = END_LEN_TINY;
        else             end_case = walk_end_e'(int'(END_HDR_TYPE) + (r - 88) % 6);

        // Header, sometimes with a longer configuration descriptor.
        add_desc(($urandom_range(0, 3) == 0) ? $urandom_range(9, 12) : 9, DT_CONFIG,
                 8'h00, 8'h00, 16'h0000);

        // Directed descriptors: video control context, its class-specific
        // descriptor, an endpoint with every max packet bit set, and the shortest
        // legal descriptor of an unknown type.
        add_desc(9, DT_INTERFACE, CLASS_VIDEO, SUBCLASS_VC, 16'h0000);
        add_desc(3, DT_CS_IFACE, 8'h00, 8'h00, 16'h0000);
        add_desc(7, DT_ENDPOINT, 8'h00, 8'h00, 16'hFFFF);
        add_desc(2, 8'hFF, 8'h00, 8'h00, 16'h0000);

        // Random well-formed body with mostly realistic lengths.
        while (blob.size() < BODY_BYTES) begin
            case ($urandom_range(0, 9))
                0, 1: add_desc(($urandom_range(0, 3) == 0) ? $urandom_range(2, 12) : 9,
                               DT_INTERFACE,
                               $urandom_range(0, 1) ? CLASS_VIDEO : 8'($urandom),
                               8'($urandom_range(0, 3)), 16'h0000);
                2, 3: add_desc(($urandom_range(0, 3) == 0) ? $urandom_range(2, 10) : 7,
                               DT_ENDPOINT, 8'h00, 8'h00, 16'($urandom));
                4, 5, 6: add_desc($urandom_range(2, 20), DT_CS_IFACE,
                                  8'h00, 8'h00, 16'h0000);
                7: add_desc($urandom_range(2, 8), DT_CS_EP, 8'h00, 8'h00, 16'h0000);
                8: add_desc(($urandom_range(0, 3) == 0) ? $urandom_range(2, 10) : 8,
                            DT_IAD, 8'h00, 8'h00, 16'h0000);
                default: add_desc(($urandom_range(0, 40) == 0) ? $urandom_range(200, 255)
                                                                : $urandom_range(2, 40),
                                  8'($urandom), 8'h00, 8'h00, 16'h0000);
            endcase
        end

        // Ending of the blob and the header fields that go with it.
        total = blob.size();
        cut = blob.size() - 1;
        case (end_case)
            END_STRAY: begin
                blob.push_back(8'($urandom));
                total = blob.size() + $urandom_range(0, 300);
                cut = blob.size() - 1;
            end
            END_PAST_TOTAL: begin
                len = $urandom_range(3, 255);
                total = blob.size() + $urandom_range(2, len - 1);
                add_desc(len, 8'($urandom), 8'h00, 8'h00, 16'h0000);
                cut = blob.size() - 1;
            end
            END_CUT_SHORT: begin
                len = $urandom_range(3, 40);
                total = $urandom_range(blob.size() + 64, 65535);
                cut = blob.size() + $urandom_range(1, len - 1);
                add_desc(len, 8'($urandom), 8'h00, 8'h00, 16'h0000);
            end
            END_LEN_TINY: begin
                total = $urandom_range(blob.size() + 64, 65535);
                add_desc($urandom_range(0, 1), 8'($urandom), 8'h00, 8'h00, 16'h0000);
                cut = blob.size() - 1;
            end
            END_HDR_TYPE:   blob[1] = DT_CONFIG ^ 8'($urandom_range(1, 255));
            END_HDR_SHORT:  cut = $urandom_range(0, HDR_LEN - 2);
            END_TOTAL_TINY: total = $urandom_range(0, 1);
            END_CFG_SHORT:  blob[0] = 8'($urandom_range(0, HDR_LEN - 1));
            END_CFG_PAST:   total = $urandom_range(2, HDR_LEN - 1);
            END_CFG_CLAMP:  cut = HDR_LEN - 1;
            default: ;
        endcase
        blob[2] = total[7:0];
        blob[3] = total[15:8];

        // Everything after the flagged byte, and the trailing noise, must be dropped.
        foreach (blob[i])
            blob_items.push_back('{data: blob[i], last: (i == cut)});
        repeat (NOISE_BYTES)
            blob_items.push_back('{data: 8'($urandom), last: 1'($urandom)});

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        while (blob_items.size() != 0 || s_tvalid)
            @(posedge aclk);
        while (pending_records.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Walk ending %s: %0d bytes sent, %0d records checked, %0d of 9 kinds seen",
                 end_case.name(), bytes_taken, records_checked, $countones(kinds_seen));
        $display("Errors: %0d (first ten shown)", error_count);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### files.f
rtl/core/ucdw_pkg.sv
rtl/core/ucdw_classify.sv
rtl/core/usb_config_descriptor_walker.sv
dv/tb.sv
